// ----- hdl/tma_pkg.sv -----
`timescale 1ns / 1ps

package tma_pkg;

  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 16;
  localparam int TALLY_W = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              tile_end;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  mean_red;
    logic [CHAN_W-1:0]  mean_green;
    logic [CHAN_W-1:0]  mean_blue;
    logic [TALLY_W-1:0] tile_pixels;
    logic               overflowed;
  } result_t;

  // running tile totals handed from the accumulator to the divider and the output register
  typedef struct packed {
    logic [SUM_W-1:0]   red_total;
    logic [SUM_W-1:0]   green_total;
    logic [SUM_W-1:0]   blue_total;
    logic [TALLY_W-1:0] pixel_tally;
    logic               excess_seen;
  } accum_t;

endpackage

// ----- hdl/tma_accum.sv -----
`timescale 1ns / 1ps

module tma_accum #(
  parameter int PIXEL_LIMIT = 144
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            add,
  input  tma_pkg::pixel_t px,
  input  logic            clear,
  output tma_pkg::accum_t acc
);

  localparam logic [tma_pkg::TALLY_W-1:0] LIMIT = tma_pkg::TALLY_W'(PIXEL_LIMIT);

  logic room;

  assign room = acc.pixel_tally < LIMIT;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (add) begin
      if (room) begin
        acc.red_total   <= acc.red_total + tma_pkg::SUM_W'(px.red);
        acc.green_total <= acc.green_total + tma_pkg::SUM_W'(px.green);
        acc.blue_total  <= acc.blue_total + tma_pkg::SUM_W'(px.blue);
        acc.pixel_tally <= acc.pixel_tally + 1'b1;
      end else begin
        // pixel past the tile limit is dropped and flagged
        acc.excess_seen <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tma_divider.sv -----
`timescale 1ns / 1ps

module tma_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tma_pkg::SUM_W-1:0]   dividend,
  input  logic [tma_pkg::TALLY_W-1:0] divisor,
  output logic                        done,
  output logic [tma_pkg::CHAN_W-1:0]  quotient
);

  // restoring division, one quotient bit per cycle, msb first
  logic                             running;
  logic [2:0]                       step;
  logic [tma_pkg::SUM_W-1:0]        rem;
  logic [tma_pkg::CHAN_W-1:0]       q;
  logic [tma_pkg::SUM_W-1:0]        shifted;
  logic                             fits;

  assign shifted  = tma_pkg::SUM_W'(divisor) << step;
  assign fits     = rem >= shifted;
  assign done     = running && (step == 3'd0);
  assign quotient = {q[tma_pkg::CHAN_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= 3'd0;
    end else if (start) begin
      running <= 1'b1;
      step    <= 3'd7;
    end else if (running) begin
      step <= step - 3'd1;
      if (step == 3'd0) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      q   <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - shifted;
      end
      q <= quotient;
    end
  end

endmodule

// ----- hdl/tile_mosaic_averager.sv -----
`timescale 1ns / 1ps

// block averager for mosaic pixelation. pixels of one tile come in one per
// transfer (start high while busy is low); a pixel without tile_end leaves
// busy low, so a pixel stream runs at one per clock while no tile ends.
// the pixel carrying tile_end raises busy while one shared restoring
// divider works through red, green and blue in turn, a load state plus
// eight quotient bits each. the result appears on result for
// exactly one cycle with done high, and the receiver cannot stall it; it
// must take every result in that cycle. a new pixel may be transferred in
// the same cycle as done. pixels past the limit of TILE_SIDE squared
// (capped at 255) are dropped and reported through overflowed.
module tile_mosaic_averager #(
  parameter int TILE_SIDE = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tma_pkg::pixel_t  pixel,
  output logic             busy,
  output logic             done,
  output tma_pkg::result_t result
);

  localparam int RAW_LIMIT   = TILE_SIDE * TILE_SIDE;
  localparam int PIXEL_LIMIT = (RAW_LIMIT > 255) ? 255 : RAW_LIMIT;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // channel codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   chan;
  logic                         accept;
  logic                         div_start;
  logic                         div_done;
  logic [tma_pkg::CHAN_W-1:0]   div_q;
  logic [tma_pkg::CHAN_W-1:0]   mean_gated;
  logic [tma_pkg::SUM_W-1:0]    dividend;
  logic [tma_pkg::CHAN_W-1:0]   mean_red;
  logic [tma_pkg::CHAN_W-1:0]   mean_green;
  logic                         last_chan;
  tma_pkg::accum_t              acc;

  assign busy      = state != ST_IDLE;
  assign accept    = start && !busy;
  assign div_start = state == ST_LOAD;
  assign last_chan = chan == CH_BLUE;

  // empty tile gives zero means instead of a divide by zero
  assign mean_gated = div_q & {tma_pkg::CHAN_W{acc.pixel_tally != '0}};

  // totals stay frozen while busy, so the divider reads them directly
  tma_accum #(
    .PIXEL_LIMIT(PIXEL_LIMIT)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .add   (accept),
    .px    (pixel),
    .clear (div_done && last_chan),
    .acc   (acc)
  );

  always_comb begin
    case (chan)
      CH_RED:   dividend = acc.red_total;
      CH_GREEN: dividend = acc.green_total;
      default:  dividend = acc.blue_total;
    endcase
  end

  tma_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (acc.pixel_tally),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer: tile end starts the red, green, blue division pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chan  <= CH_RED;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && pixel.tile_end) begin
            state <= ST_LOAD;
            chan  <= CH_RED;
          end
        end
        ST_LOAD: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (div_done) begin
            if (last_chan) begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end else begin
              state <= ST_LOAD;
              chan  <= chan + 2'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // per channel means and the output register
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (chan)
        CH_RED:   mean_red   <= mean_gated;
        CH_GREEN: mean_green <= mean_gated;
        default: begin
          result.mean_red    <= mean_red;
          result.mean_green  <= mean_green;
          result.mean_blue   <= mean_gated;
          result.tile_pixels <= acc.pixel_tally;
          result.overflowed  <= acc.excess_seen;
        end
      endcase
    end
  end

  // a result only follows a finished division pass
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_RUN && $past(chan) == CH_BLUE)
    else $error("result without a completed division pass");

  // the pixel marked last is counted unless the tally is already at the limit, so a tile is never empty
  assert property (@(posedge clk) disable iff (rst)
    done |-> result.tile_pixels != '0)
    else $error("empty tile reported");

  // the tally never passes the pixel limit
  assert property (@(posedge clk) disable iff (rst)
    acc.pixel_tally <= tma_pkg::TALLY_W'(PIXEL_LIMIT))
    else $error("pixel tally past limit");

  // totals must hold while the divider works on them
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && $past(state) == ST_RUN) |-> $stable(acc))
    else $error("totals changed during division");

endmodule

// ----- tb/tile_mosaic_averager_checker.sv -----
`timescale 1ns / 1ps

module tile_mosaic_averager_checker #(
  parameter int TILE_SIDE = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  tma_pkg::pixel_t  pixel,
  input  logic             done,
  input  tma_pkg::result_t result,
  output int               mismatches,
  output int               outstanding
);

  localparam int PIXEL_CAP = (TILE_SIDE * TILE_SIDE > 255) ? 255 : TILE_SIDE * TILE_SIDE;

  logic [tma_pkg::SUM_W-1:0]   red_sum;
  logic [tma_pkg::SUM_W-1:0]   green_sum;
  logic [tma_pkg::SUM_W-1:0]   blue_sum;
  logic [tma_pkg::TALLY_W-1:0] tally;
  logic                        excess;
  tma_pkg::result_t            tile_means_q[$];

  // truncated channel mean, zero for an empty tile
  function automatic logic [tma_pkg::CHAN_W-1:0] channel_mean(
    logic [tma_pkg::SUM_W-1:0]   sum,
    logic [tma_pkg::TALLY_W-1:0] count
  );
    logic [tma_pkg::SUM_W-1:0] quotient;
    if (count == '0) return '0;
    quotient = sum / tma_pkg::SUM_W'(count);
    return quotient[tma_pkg::CHAN_W-1:0];
  endfunction

  task automatic accumulate_pixel(input tma_pkg::pixel_t p);
    tma_pkg::result_t means;
    if (int'(tally) < PIXEL_CAP) begin
      red_sum   = red_sum + tma_pkg::SUM_W'(p.red);
      green_sum = green_sum + tma_pkg::SUM_W'(p.green);
      blue_sum  = blue_sum + tma_pkg::SUM_W'(p.blue);
      tally     = tally + 1'b1;
    end else begin
      excess = 1'b1;
    end
    if (p.tile_end) begin
      means.mean_red    = channel_mean(red_sum, tally);
      means.mean_green  = channel_mean(green_sum, tally);
      means.mean_blue   = channel_mean(blue_sum, tally);
      means.tile_pixels = tally;
      means.overflowed  = excess;
      tile_means_q.push_back(means);
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      tally     = '0;
      excess    = 1'b0;
    end
  endtask

  task automatic compare_means(input tma_pkg::result_t got);
    tma_pkg::result_t want;
    if (tile_means_q.size() == 0) begin
      $error("result with no tile pending: %p", got);
      mismatches++;
      return;
    end
    want = tile_means_q.pop_front();
    if (got.mean_red !== want.mean_red) begin
      $error("mean_red: expected %0d, got %0d", want.mean_red, got.mean_red);
      mismatches++;
    end
    if (got.mean_green !== want.mean_green) begin
      $error("mean_green: expected %0d, got %0d", want.mean_green, got.mean_green);
      mismatches++;
    end
    if (got.mean_blue !== want.mean_blue) begin
      $error("mean_blue: expected %0d, got %0d", want.mean_blue, got.mean_blue);
      mismatches++;
    end
    if (got.tile_pixels !== want.tile_pixels) begin
      $error("tile_pixels: expected %0d, got %0d", want.tile_pixels, got.tile_pixels);
      mismatches++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
      mismatches++;
    end
  endtask

  // results are compared before the pixel of the same edge is taken in
  always @(posedge clk) begin
    if (rst) begin
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      tally     = '0;
      excess    = 1'b0;
      tile_means_q.delete();
    end else begin
      if (done === 1'b1) compare_means(result);
      if (start && busy === 1'b0) accumulate_pixel(pixel);
    end
    outstanding = tile_means_q.size();
  end

endmodule

// ----- tb/tile_mosaic_averager_tb.sv -----
`timescale 1ns / 1ps

// stimulus and verdict for the mosaic tile averager; prediction and
// comparison live in the checker instantiated beside the block
module tile_mosaic_averager_tb;

  localparam int TILE_SIDE   = 12;
  localparam int TILE_CAP    = TILE_SIDE * TILE_SIDE;
  localparam int PIXEL_GOAL  = 1100;
  // settling time after the last result is drained, before the verdict
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 1000;

  // how the channel values of a tile are chosen
  typedef enum int {
    SHADE_RANDOM,
    SHADE_FULL,
    SHADE_ZERO,
    SHADE_ANY
  } shade_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  tma_pkg::pixel_t  pixel = '0;
  logic             busy;
  logic             done;
  tma_pkg::result_t result;

  int mismatches;
  int outstanding;
  int stall_cycles = 0;
  int pixels_sent = 0;
  int burst_left = 0;

  tile_mosaic_averager #(
    .TILE_SIDE(TILE_SIDE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .pixel(pixel),
    .busy(busy),
    .done(done),
    .result(result)
  );

  tile_mosaic_averager_checker #(
    .TILE_SIDE(TILE_SIDE)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pixel(pixel),
    .done(done),
    .result(result),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: any pixel transfer or result restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // hold the pixel with start high until a transfer happens; returns on
  // the accepting edge so the next pixel can follow back to back
  task automatic send_pixel(input tma_pkg::pixel_t p);
    start <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
  endtask

  // sender pacing: bursts of transfers separated by idle gaps of random
  // length, so gaps land on every cycle of the divider's busy window
  task automatic pace_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      pixel <= tma_pkg::pixel_t'($urandom);
      repeat ($urandom_range(1, 30)) @(posedge clk);
      // one burst in four runs long with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  // stop sending until every pending tile has produced its result
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [tma_pkg::CHAN_W-1:0] pick_channel(input shade_t shade);
    case (shade)
      SHADE_FULL: return '1;
      SHADE_ZERO: return '0;
      SHADE_ANY: begin
        case ($urandom_range(0, 3))
          0: return '1;
          1: return '0;
          default: return tma_pkg::CHAN_W'($urandom);
        endcase
      end
      default: return tma_pkg::CHAN_W'($urandom);
    endcase
  endfunction

  task automatic send_tile(input int len, input shade_t shade);
    tma_pkg::pixel_t p;
    for (int i = 0; i < len; i++) begin
      p.red      = pick_channel(shade);
      p.green    = pick_channel(shade);
      p.blue     = pick_channel(shade);
      p.tile_end = (i == len - 1);
      pace_sender();
      send_pixel(p);
    end
  endtask

  initial begin
    int     len;
    shade_t shade;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-pixel tiles at the channel extremes and mixed patterns
    send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF, tile_end: 1'b1});
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, tile_end: 1'b1});
    send_pixel('{red: 8'hAA, green: 8'h55, blue: 8'h0F, tile_end: 1'b1});
    send_pixel('{red: 8'h55, green: 8'hAA, blue: 8'hF0, tile_end: 1'b1});
    // two pixels, odd sums: mean truncates down
    send_pixel('{red: 8'hFF, green: 8'h00, blue: 8'h01, tile_end: 1'b0});
    send_pixel('{red: 8'h00, green: 8'hFF, blue: 8'h02, tile_end: 1'b1});
    // three pixels, remainders of zero and two
    send_pixel('{red: 8'h01, green: 8'h02, blue: 8'hFE, tile_end: 1'b0});
    send_pixel('{red: 8'h01, green: 8'h02, blue: 8'hFF, tile_end: 1'b0});
    send_pixel('{red: 8'h01, green: 8'h01, blue: 8'hFF, tile_end: 1'b1});
    // pixel offered while the divider is still busy with the tile above
    send_pixel('{red: 8'h80, green: 8'h7F, blue: 8'h80, tile_end: 1'b1});
    send_tile(4, SHADE_RANDOM);
    send_tile(5, SHADE_ANY);
    drain_results();

    // random tiles; the full and overflowing sizes are the deep cases
    while (pixels_sent < PIXEL_GOAL) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: len = $urandom_range(1, 16);
        4, 5:       len = $urandom_range(17, TILE_CAP - 1);
        6:          len = TILE_CAP;
        7:          len = TILE_CAP + 1;
        8:          len = $urandom_range(TILE_CAP + 2, TILE_CAP + 20);
        default:    len = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 5))
        0:       shade = SHADE_FULL;
        1:       shade = SHADE_ZERO;
        2:       shade = SHADE_ANY;
        default: shade = SHADE_RANDOM;
      endcase
      // now and then let every result come home before the next tile
      if ($urandom_range(0, 7) == 0) drain_results();
      send_tile(len, shade);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
